// ===== src/spp_pkg.sv =====
// spp_pkg: shared widths, register indexes and transaction types of the stipple texel generator
// no dependencies; used by spp_cfg, spp_divider users and the top level
package spp_pkg;

	localparam int SPP_ROW_LENGTH = 512;

	localparam int COL_W      = 9;
	localparam int ROW_W      = 9;
	localparam int WORD_W     = 8;
	localparam int COUNT_W    = 3;
	localparam int CAP_W      = 10;
	localparam int TEXEL_W    = 8;
	localparam int HEIGHT_W   = 9;
	localparam int PLEN_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int R4_W       = 9;
	localparam int A4_W       = 10;
	localparam int HH4_W      = 9;
	localparam int C2_W       = 9;
	localparam int SQ_W       = 18;
	localparam int RH_W       = 36;
	localparam int NUM_W      = 17;
	localparam int DIST_W     = 10;
	localparam int DIST_SQ_W  = 20;
	localparam int DELTA_W    = 12;
	localparam int PROD_W     = 38;
	localparam int SUM_W      = 39;

	localparam logic [COUNT_W-1:0] TRI_COUNT    = 3'd4;
	localparam logic [COUNT_W-1:0] SINGLE_COUNT = 3'd1;

	localparam logic [TEXEL_W-1:0] TEXEL_ON  = 8'hFF;
	localparam logic [TEXEL_W-1:0] TEXEL_OFF = 8'h00;

	localparam logic [COUNT_W-1:0] RST_COUNT  = 3'd2;
	localparam logic [WORD_W-1:0]  RST_WORD_A = 8'd4;
	localparam logic [WORD_W-1:0]  RST_WORD_B = 8'd4;
	localparam logic [WORD_W-1:0]  RST_WORD_C = 8'd0;
	localparam logic [WORD_W-1:0]  RST_WORD_D = 8'd0;
	localparam logic [WORD_W-1:0]  RST_DASH_H = 8'd8;
	localparam logic [CAP_W-1:0]   RST_CAP    = 10'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_COUNT = 3'd0,
		CFG_WORD_A        = 3'd1,
		CFG_WORD_B        = 3'd2,
		CFG_WORD_C        = 3'd3,
		CFG_WORD_D        = 3'd4,
		CFG_DASH_HEIGHT   = 3'd5,
		CFG_CAP_RADIUS    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} in_t;

	typedef struct packed {
		logic [TEXEL_W-1:0]  texel_value;
		logic                inside_tile;
		logic [HEIGHT_W-1:0] tile_height;
	} out_t;

	typedef struct packed {
		logic                tri_mode;
		logic                plen_bad;
		logic [PLEN_W-1:0]   plen;
		logic [HEIGHT_W-1:0] height;
		logic [WORD_W-1:0]   word_a;
		logic [WORD_W-1:0]   word_b;
		logic [WORD_W-1:0]   word_c;
		logic [WORD_W-1:0]   word_d;
		logic [R4_W-1:0]     r4;
		logic [A4_W-1:0]     a4;
		logic [HH4_W-1:0]    hh4;
		logic [C2_W-1:0]     c2;
		logic [SQ_W-1:0]     rr;
		logic [SQ_W-1:0]     hh2;
		logic [RH_W-1:0]     rh;
	} cfg_t;

endpackage

// ===== src/spp_divider.sv =====
// spp_divider: three-stage pipelined restoring divider, quotient and remainder
// uses no package; an operand pair passes through the registered stages st_s1, st_s2 and st_s3 to quot and remain
module spp_divider #(
	parameter int NW = 9,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] remain
);

	localparam int STEPS = (NW + 2) / 3;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [NW-1:0] num;
		logic [NW-1:0] quo;
		logic [DW-1:0] den;
	} div_t;

	function automatic div_t advance(div_t cur, int first);
		div_t        nxt;
		logic [DW:0] trial;
		int          idx;
		nxt = cur;
		for (int j = 0; j < STEPS; j++) begin
			idx = NW - 1 - first - j;
			if (idx >= 0) begin
				trial = {nxt.rem, nxt.num[idx]};
				if (trial >= {1'b0, nxt.den}) begin
					trial        = trial - {1'b0, nxt.den};
					nxt.quo[idx] = 1'b1;
				end
				nxt.rem = trial[DW-1:0];
			end
		end
		return nxt;
	endfunction

	div_t st0;
	div_t st_s1;
	div_t st_s2;
	div_t st_s3;

	always_comb begin
		st0.rem = '0;
		st0.num = numer;
		st0.quo = '0;
		st0.den = denom;
	end

	always_ff @(posedge clk) begin
		st_s1 <= advance(st0, 0);
		st_s2 <= advance(st_s1, STEPS);
		st_s3 <= advance(st_s2, 2 * STEPS);
	end

	assign quot   = st_s3.quo;
	assign remain = st_s3.rem;

endmodule

// ===== src/spp_cfg.sv =====
// spp_cfg: pattern registers and the per-pattern values derived from them
// depends on spp_pkg; a write lands in the pattern registers, then in the derived values of cfg_q
module spp_cfg #(
	parameter int ROW_LENGTH = spp_pkg::SPP_ROW_LENGTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output spp_pkg::cfg_t                    cfg
);

	localparam int AVAIL   = ROW_LENGTH - 2;
	localparam int COUNT_W = spp_pkg::COUNT_W;
	localparam int WORD_W  = spp_pkg::WORD_W;
	localparam int CAP_W   = spp_pkg::CAP_W;
	localparam int PLEN_W  = spp_pkg::PLEN_W;
	localparam int HEIGHT_W = spp_pkg::HEIGHT_W;
	localparam int R4_W    = spp_pkg::R4_W;
	localparam int SQ_W    = spp_pkg::SQ_W;
	localparam int RH_W    = spp_pkg::RH_W;

	logic [COUNT_W-1:0] count_q;
	logic [WORD_W-1:0]  word_a_q;
	logic [WORD_W-1:0]  word_b_q;
	logic [WORD_W-1:0]  word_c_q;
	logic [WORD_W-1:0]  word_d_q;
	logic [WORD_W-1:0]  dash_h_q;
	logic [CAP_W-1:0]   cap_q;

	logic                tri_d;
	logic [PLEN_W-1:0]   plen_d;
	logic [HEIGHT_W-1:0] height_d;
	logic [R4_W-1:0]     two_a;
	logic [R4_W-1:0]     r4_d;

	spp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= spp_pkg::RST_COUNT;
			word_a_q <= spp_pkg::RST_WORD_A;
			word_b_q <= spp_pkg::RST_WORD_B;
			word_c_q <= spp_pkg::RST_WORD_C;
			word_d_q <= spp_pkg::RST_WORD_D;
			dash_h_q <= spp_pkg::RST_DASH_H;
			cap_q    <= spp_pkg::RST_CAP;
		end else if (cfg_we) begin
			unique case (spp_pkg::cfg_idx_t'(cfg_index))
				spp_pkg::CFG_PATTERN_COUNT: count_q  <= cfg_data[COUNT_W-1:0];
				spp_pkg::CFG_WORD_A:        word_a_q <= cfg_data[WORD_W-1:0];
				spp_pkg::CFG_WORD_B:        word_b_q <= cfg_data[WORD_W-1:0];
				spp_pkg::CFG_WORD_C:        word_c_q <= cfg_data[WORD_W-1:0];
				spp_pkg::CFG_WORD_D:        word_d_q <= cfg_data[WORD_W-1:0];
				spp_pkg::CFG_DASH_HEIGHT:   dash_h_q <= cfg_data[WORD_W-1:0];
				spp_pkg::CFG_CAP_RADIUS:    cap_q    <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tri_d = (count_q == spp_pkg::TRI_COUNT);
		two_a = {word_a_q, 1'b0};
		if (tri_d) begin
			plen_d   = PLEN_W'(two_a) + PLEN_W'(word_b_q);
			height_d = HEIGHT_W'(word_c_q) + HEIGHT_W'(word_d_q);
		end else begin
			plen_d   = PLEN_W'(word_a_q)
				+ ((count_q == spp_pkg::SINGLE_COUNT) ? '0 : PLEN_W'(word_b_q));
			height_d = HEIGHT_W'(dash_h_q);
		end
		r4_d = (cap_q < CAP_W'(two_a)) ? cap_q[R4_W-1:0] : two_a;
	end

	// three levels: direct values, squares, then the product of the squares
	always_ff @(posedge clk) begin
		cfg_q.tri_mode <= tri_d;
		cfg_q.plen_bad <= (plen_d == '0) || (int'(plen_d) > AVAIL);
		cfg_q.plen     <= plen_d;
		cfg_q.height   <= height_d;
		cfg_q.word_a   <= word_a_q;
		cfg_q.word_b   <= word_b_q;
		cfg_q.word_c   <= word_c_q;
		cfg_q.word_d   <= word_d_q;
		cfg_q.r4       <= r4_d;
		cfg_q.a4       <= {word_a_q, 2'b00};
		cfg_q.hh4      <= {dash_h_q, 1'b0};
		cfg_q.c2       <= {word_c_q, 1'b0};
		cfg_q.rr       <= SQ_W'(cfg_q.r4) * SQ_W'(cfg_q.r4);
		cfg_q.hh2      <= SQ_W'(cfg_q.hh4) * SQ_W'(cfg_q.hh4);
		cfg_q.rh       <= RH_W'(cfg_q.rr) * RH_W'(cfg_q.hh2);
	end

	assign cfg = cfg_q;

endmodule

// ===== src/stipple_pattern_pixel_generator_unit.sv =====
// stipple_pattern_pixel_generator_unit: one texel transaction per clock while busy is low, no stall on the result side
// output: the result passes through the registers s1 to s9 and is on the ports for one cycle
// the depth is set by the three-stage period and notch dividers and the two-multiply cap test
// reset: busy is high for one cycle after arst_n rises, registers take their reset pattern
// depends on spp_pkg, spp_cfg and spp_divider
module stipple_pattern_pixel_generator_unit #(
	parameter int ROW_LENGTH = spp_pkg::SPP_ROW_LENGTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  spp_pkg::in_t                   item,
	output logic                           done,
	output spp_pkg::out_t                  result
);

	localparam int AVAIL     = ROW_LENGTH - 2;
	localparam int AVW       = $clog2(ROW_LENGTH);
	localparam int PLEN_W    = spp_pkg::PLEN_W;
	localparam int LW        = ((AVW > PLEN_W) ? AVW : PLEN_W) + 1;
	localparam int PLEN_XW   = PLEN_W + 1;
	localparam int COL_W     = spp_pkg::COL_W;
	localparam int ROW_W     = spp_pkg::ROW_W;
	localparam int WORD_W    = spp_pkg::WORD_W;
	localparam int NUM_W     = spp_pkg::NUM_W;
	localparam int C2_W      = spp_pkg::C2_W;
	localparam int A4_W      = spp_pkg::A4_W;
	localparam int A4_XW     = A4_W + 1;
	localparam int DELTA_W   = spp_pkg::DELTA_W;
	localparam int DIST_W    = spp_pkg::DIST_W;
	localparam int DIST_SQ_W = spp_pkg::DIST_SQ_W;
	localparam int PROD_W    = spp_pkg::PROD_W;
	localparam int SUM_W     = spp_pkg::SUM_W;

	spp_pkg::cfg_t cfg;

	logic busy_q;
	logic accept;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic done_s9;

	logic [COL_W-1:0]  col_s1, col_s2, col_s3, col_s4;
	logic [ROW_W-1:0]  row_s1, row_s2, row_s3, row_s4, row_s5;
	logic [NUM_W-1:0]  numer_s2;
	logic [PLEN_W-1:0] pos_rem_s4;
	logic [PLEN_W-1:0] len_rem_s4;
	logic [NUM_W-1:0]  notch_quo_s5;
	logic              inside_s5, inside_s6, inside_s7, inside_s8;
	logic [PLEN_W-1:0] pos_s5;
	logic              need_ell_s6, need_ell_s7, need_ell_s8;
	logic              fixed_on_s6, fixed_on_s7, fixed_on_s8;
	logic [DIST_W-1:0]    dxa_s6, dya_s6;
	logic [DIST_SQ_W-1:0] dx2_s7, dy2_s7;
	logic [PROD_W-1:0]    p1_s8, p2_s8;
	spp_pkg::out_t        result_s9;

	logic [ROW_W-1:0]  k_d;
	logic [WORD_W-1:0] trg_d;
	logic [NUM_W-1:0]  numer_d;

	logic [LW-1:0]     edge_col;
	logic              inside_d;
	logic [PLEN_W-1:0] pos_d;

	logic [WORD_W-1:0]  width_d;
	logic [PLEN_W-1:0]  left_d;
	logic               notch_on;
	logic               tri_on;
	logic [A4_W-1:0]    x4;
	logic               beyond;
	logic               in_left, in_right;
	logic [A4_W-1:0]    cx4;
	logic [DELTA_W-1:0] dx4, dy4;
	logic [DIST_W-1:0]  dxa_d, dya_d;
	logic               need_ell_d, fixed_on_d;

	logic          ell_on;
	spp_pkg::out_t result_d;

	spp_cfg #(.ROW_LENGTH(ROW_LENGTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			done_s9  <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			done_s9  <= valid_s8;
		end
	end

	// notch numerator 2*(c-k)*b + c for triangle row k
	always_comb begin
		k_d     = row_s1 - ROW_W'(cfg.word_d);
		trg_d   = cfg.word_c - k_d[WORD_W-1:0];
		numer_d = NUM_W'({trg_d, 1'b0}) * NUM_W'(cfg.word_b) + NUM_W'(cfg.word_c);
	end

	spp_divider #(.NW(COL_W), .DW(PLEN_W)) u_pos_div (
		.clk    (clk),
		.numer  (col_s1 - COL_W'(1)),
		.denom  (cfg.plen),
		.quot   (),
		.remain (pos_rem_s4)
	);

	spp_divider #(.NW(AVW), .DW(PLEN_W)) u_len_div (
		.clk    (clk),
		.numer  (AVW'(AVAIL)),
		.denom  (cfg.plen),
		.quot   (),
		.remain (len_rem_s4)
	);

	spp_divider #(.NW(NUM_W), .DW(C2_W)) u_notch_div (
		.clk    (clk),
		.numer  (numer_s2),
		.denom  (cfg.c2),
		.quot   (notch_quo_s5),
		.remain ()
	);

	// tile extent and period position with the edge columns folded in
	always_comb begin
		edge_col = LW'(AVAIL) - LW'(len_rem_s4) + LW'(1);
		inside_d = !cfg.plen_bad && (LW'(col_s4) <= edge_col)
			&& (row_s4 < cfg.height);
		priority if (col_s4 == '0) begin
			pos_d = '0;
		end else if (LW'(col_s4) == edge_col) begin
			pos_d = cfg.plen - PLEN_W'(1);
		end else begin
			pos_d = pos_rem_s4;
		end
	end

	// notch span and cap geometry in quarter pixels
	always_comb begin
		width_d  = notch_quo_s5[WORD_W-1:0];
		left_d   = (cfg.plen - PLEN_W'(width_d)) >> 1;
		notch_on = (pos_s5 >= left_d)
			&& (PLEN_XW'(pos_s5) < PLEN_XW'(left_d) + PLEN_XW'(width_d));
		tri_on   = (row_s5 < ROW_W'(cfg.word_d)) || notch_on;

		x4       = {pos_s5[WORD_W-1:0], 2'b00};
		beyond   = pos_s5 >= PLEN_W'(cfg.word_a);
		in_left  = x4 < A4_W'(cfg.r4);
		in_right = (A4_XW'(x4) + A4_XW'(cfg.r4)) >= A4_XW'(cfg.a4);
		cx4      = in_left ? A4_W'(cfg.r4) : cfg.a4 - A4_W'(cfg.r4);
		dx4      = DELTA_W'(x4) + DELTA_W'(2) - DELTA_W'(cx4);
		dy4      = DELTA_W'({row_s5, 2'b00}) + DELTA_W'(2) - DELTA_W'(cfg.hh4);
		dxa_d    = dx4[DELTA_W-1] ? DIST_W'(-dx4) : DIST_W'(dx4);
		dya_d    = dy4[DELTA_W-1] ? DIST_W'(-dy4) : DIST_W'(dy4);

		priority if (cfg.tri_mode) begin
			fixed_on_d = tri_on;
			need_ell_d = 1'b0;
		end else if (beyond) begin
			fixed_on_d = 1'b0;
			need_ell_d = 1'b0;
		end else if (!(in_left || in_right)) begin
			fixed_on_d = 1'b1;
			need_ell_d = 1'b0;
		end else begin
			fixed_on_d = 1'b0;
			need_ell_d = 1'b1;
		end
	end

	always_comb begin
		ell_on = (SUM_W'(p1_s8) + SUM_W'(p2_s8)) <= SUM_W'(cfg.rh);
		result_d.texel_value = (inside_s8 && (need_ell_s8 ? ell_on : fixed_on_s8))
			? spp_pkg::TEXEL_ON : spp_pkg::TEXEL_OFF;
		result_d.inside_tile = inside_s8;
		result_d.tile_height = cfg.height;
	end

	always_ff @(posedge clk) begin
		col_s1      <= item.column;
		row_s1      <= item.row;
		col_s2      <= col_s1;
		row_s2      <= row_s1;
		numer_s2    <= numer_d;
		col_s3      <= col_s2;
		row_s3      <= row_s2;
		col_s4      <= col_s3;
		row_s4      <= row_s3;
		inside_s5   <= inside_d;
		pos_s5      <= pos_d;
		row_s5      <= row_s4;
		inside_s6   <= inside_s5;
		need_ell_s6 <= need_ell_d;
		fixed_on_s6 <= fixed_on_d;
		dxa_s6      <= dxa_d;
		dya_s6      <= dya_d;
		inside_s7   <= inside_s6;
		need_ell_s7 <= need_ell_s6;
		fixed_on_s7 <= fixed_on_s6;
		dx2_s7      <= DIST_SQ_W'(dxa_s6) * DIST_SQ_W'(dxa_s6);
		dy2_s7      <= DIST_SQ_W'(dya_s6) * DIST_SQ_W'(dya_s6);
		inside_s8   <= inside_s7;
		need_ell_s8 <= need_ell_s7;
		fixed_on_s8 <= fixed_on_s7;
		p1_s8       <= PROD_W'(dx2_s7) * PROD_W'(cfg.hh2);
		p2_s8       <= PROD_W'(dy2_s7) * PROD_W'(cfg.rr);
		result_s9   <= result_d;
	end

	assign done   = done_s9;
	assign result = result_s9;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##9 done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 9))
		else $error("result without an accepted transaction");

	a_inside_row: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.inside_tile) |-> ($past(item.row, 9) < result.tile_height))
		else $error("texel marked inside at a row beyond the tile");

endmodule
